/* rtl/core/prt_pkg.sv */
// prt_pkg: shared types and codes for the pending request table
// no dependencies
package prt_pkg;

    typedef enum logic [2:0] {
        ACT_INSERT  = 3'd0,
        ACT_LOOKUP  = 3'd1,
        ACT_LOOKRM  = 3'd2,
        ACT_RMHDL   = 3'd3,
        ACT_EXPIRE  = 3'd4,
        ACT_POP     = 3'd5
    } t_action;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] handle;
        logic [31:0] prior;
        logic [31:0] stamp;
    } t_entry;

    // per-operation control broadcast to every cell
    typedef struct packed {
        logic        ins;
        logic        match_seq;
        logic        match_hdl;
        logic        expire;
        logic        ignore;
        logic        first_only;
        logic        do_remove;
        logic [31:0] key;
        logic [31:0] now;
        logic [31:0] age;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_OUT  = 2'd2
    } t_state;

endpackage

/* rtl/core/prt_cell.sv */
// prt_cell: one table slot; evaluates its match and shifts toward the head
// depends on prt_pkg
module prt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  prt_pkg::t_cmd   i_cmd,
    input  logic            i_exec,
    input  logic            i_load,
    input  prt_pkg::t_entry i_new,
    input  logic            i_hit_before,
    input  logic            i_drop_before,
    input  logic            i_up_valid,
    input  logic            i_up_drop,
    input  prt_pkg::t_entry i_up_entry,
    output logic            o_valid,
    output logic            o_hit,
    output logic            o_drop,
    output prt_pkg::t_entry o_entry
);
    logic            r_valid;
    prt_pkg::t_entry r_entry;
    logic            w_match;
    logic            w_expired;

    assign w_expired = (i_cmd.age == 32'd0) || ((i_cmd.now - r_entry.stamp) >= i_cmd.age);
    always_comb begin
        w_match = 1'b0;
        if (i_cmd.match_seq) w_match = r_entry.seq == i_cmd.key;
        if (i_cmd.match_hdl) w_match = r_entry.handle == i_cmd.key;
        if (i_cmd.expire)    w_match = i_cmd.ignore || w_expired;
    end
    assign o_hit  = r_valid && w_match && !(i_cmd.first_only && i_hit_before);
    assign o_drop = o_hit && i_cmd.do_remove;

    // a single drop shifts later cells down by one; multi drops repeat over cycles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_entry <= i_new;
        end else if (i_exec && (i_drop_before || o_drop)) begin
            r_valid <= i_up_valid && !i_up_drop;
            r_entry <= i_up_entry;
        end
    end
    assign o_valid = r_valid;
    assign o_entry = r_entry;
endmodule

/* rtl/core/pending_request_table_with_expiry_core.sv */
// pending_request_table_with_expiry_core: top level, cell chain plus sequencer
// depends on prt_pkg and prt_cell
//  channel | dir | handshake          | payload
//  s_axis  | in  | tvalid/tready      | tdata {ignore,now,prior,handle,seq,action}
//  m_axis  | out | tvalid/tready      | tdata {empty,occ,removed,prior,handle,seq,status}
//  cfg     | in  | cfg_valid/ready    | expiry_age
// each pass over the chain removes the oldest marked entry; a transaction goes
// through execute, result and idle, and remove by handle and expire add one
// execute pass per entry removed
// a low m_axis_tready holds the result and keeps s_axis_tready low
// sync active-low reset empties the table
module pending_request_table_with_expiry_core #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [135:0]  s_axis_tdata,  // action, seq, handle, prior, now, ignore
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [111:0]  m_axis_tdata,  // status, seq, handle, prior, removed, occ, empty
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data
);
    localparam int CW = $clog2(CAPACITY + 1);
    prt_pkg::t_state r_state, n_state;
    prt_pkg::t_cmd   r_cmd;
    prt_pkg::t_entry r_new;
    logic [2:0]      r_act;
    logic [31:0]     r_age;
    logic [CW-1:0]   r_count, r_removed;
    logic            r_found;
    logic            r_full;
    prt_pkg::t_entry r_fnd;

    logic [CAPACITY-1:0] w_valid, w_hit, w_drop, w_hb, w_db, w_load;
    prt_pkg::t_entry     w_ent [CAPACITY];
    logic                w_exec, w_any_drop, w_any_hit;
    logic                w_go, w_multi;
    prt_pkg::t_entry     w_first;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_h
                assign w_hb[g] = 1'b0;
                assign w_db[g] = 1'b0;
            end else begin : g_b
                assign w_hb[g] = w_hb[g-1] | w_hit[g-1];
                assign w_db[g] = w_db[g-1] | w_drop[g-1];
            end
            assign w_load[g] = (r_state == prt_pkg::S_EXEC) && r_cmd.ins &&
                               (r_count == CW'(g));
            prt_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(r_cmd), .i_exec(w_exec),
                .i_load(w_load[g]), .i_new(r_new), .i_hit_before(w_hb[g]),
                .i_drop_before(w_db[g]),
                .i_up_valid((g == CAPACITY-1) ? 1'b0 : w_valid[(g+1)%CAPACITY]),
                .i_up_drop(1'b0),
                .i_up_entry(w_ent[(g+1)%CAPACITY]),
                .o_valid(w_valid[g]), .o_hit(w_hit[g]), .o_drop(w_drop[g]),
                .o_entry(w_ent[g])
            );
        end
    endgenerate

    always_comb begin
        w_first = '0;
        for (int k = CAPACITY-1; k >= 0; k--) if (w_hit[k]) w_first = w_ent[k];
    end
    assign w_any_drop = |w_drop;
    assign w_any_hit  = |w_hit;
    // pop acts only when the oldest slot is the hit
    assign w_go    = (r_act != prt_pkg::ACT_POP) || w_hit[0];
    // remove by handle and expire repeat passes until nothing is marked
    assign w_multi = (r_act == prt_pkg::ACT_RMHDL) || (r_act == prt_pkg::ACT_EXPIRE);
    // only the first marked entry goes per pass
    assign w_exec = (r_state == prt_pkg::S_EXEC) && !r_cmd.ins && w_go;

    assign s_axis_tready = (r_state == prt_pkg::S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            prt_pkg::S_IDLE: if (s_axis_tvalid) n_state = prt_pkg::S_EXEC;
            prt_pkg::S_EXEC: if (r_cmd.ins || !w_any_drop || !w_multi)
                n_state = prt_pkg::S_OUT;
            prt_pkg::S_OUT:  if (m_axis_tready) n_state = prt_pkg::S_IDLE;
            default:         n_state = prt_pkg::S_IDLE;
        endcase
    end

    // cells drop only the first hit per pass: multi-remove uses first_only too
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prt_pkg::S_IDLE;
            r_age <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_valid) r_age <= cfg_data;
            if (r_state == prt_pkg::S_IDLE && s_axis_tvalid) begin
                r_act <= s_axis_tdata[2:0];
                r_new <= '{s_axis_tdata[34:3], s_axis_tdata[66:35],
                           s_axis_tdata[98:67], s_axis_tdata[130:99]};
                r_cmd.ins       <= s_axis_tdata[2:0] == prt_pkg::ACT_INSERT;
                r_cmd.match_seq <= s_axis_tdata[2:0] == prt_pkg::ACT_LOOKUP ||
                                   s_axis_tdata[2:0] == prt_pkg::ACT_LOOKRM;
                r_cmd.match_hdl <= s_axis_tdata[2:0] == prt_pkg::ACT_RMHDL;
                r_cmd.expire    <= s_axis_tdata[2:0] == prt_pkg::ACT_EXPIRE ||
                                   s_axis_tdata[2:0] == prt_pkg::ACT_POP;
                r_cmd.ignore    <= s_axis_tdata[131] &&
                                   s_axis_tdata[2:0] == prt_pkg::ACT_EXPIRE;
                r_cmd.first_only <= 1'b1;
                r_cmd.do_remove <= s_axis_tdata[2:0] != prt_pkg::ACT_LOOKUP;
                r_cmd.key <= (s_axis_tdata[2:0] == prt_pkg::ACT_RMHDL) ?
                             s_axis_tdata[66:35] : s_axis_tdata[34:3];
                r_cmd.now <= s_axis_tdata[130:99];
                r_cmd.age <= r_age;
                r_removed <= '0;
                r_found <= 1'b0;
                r_full <= 1'b0;
                r_fnd <= '0;
            end
            if (r_state == prt_pkg::S_EXEC) begin
                if (r_cmd.ins) begin
                    if (r_count != CW'(CAPACITY)) r_count <= r_count + 1'b1;
                    else r_full <= 1'b1;
                end else if (w_go) begin
                    if (w_any_hit && !r_found) begin
                        r_found <= 1'b1;
                        r_fnd <= w_first;
                    end
                    if (w_any_drop) begin
                        r_count <= r_count - 1'b1;
                        r_removed <= r_removed + 1'b1;
                    end
                end
            end
        end
    end

    logic [1:0]    w_status;
    logic [CW-1:0] w_cnt;
    logic          w_pop, w_show;
    always_comb begin
        w_pop = r_act == prt_pkg::ACT_POP;
        w_cnt = r_count;
        w_status = prt_pkg::ST_OK;
        case (r_act)
            prt_pkg::ACT_INSERT: if (r_full) w_status = prt_pkg::ST_FULL;
            prt_pkg::ACT_LOOKUP, prt_pkg::ACT_LOOKRM:
                if (!r_found) w_status = prt_pkg::ST_MISS;
            prt_pkg::ACT_RMHDL, prt_pkg::ACT_EXPIRE, prt_pkg::ACT_POP:
                if (r_removed == '0) w_status = prt_pkg::ST_MISS;
            default: w_status = prt_pkg::ST_OK;
        endcase
        w_show = (r_act == prt_pkg::ACT_LOOKUP || r_act == prt_pkg::ACT_LOOKRM) ? r_found :
                 (w_pop && r_removed != '0);
    end

    assign m_axis_tvalid = (r_state == prt_pkg::S_OUT);
    assign m_axis_tdata = {3'b0, (w_cnt == '0), 5'(w_cnt), 5'(r_removed),
                           w_show ? r_fnd.prior : 32'd0, w_show ? r_fnd.handle : 32'd0,
                           w_show ? r_fnd.seq : 32'd0, w_status};

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("count overflow");
    a_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_load)) else $error("multi load");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("overlap");
endmodule

/* tb/pending_request_table_with_expiry_core_test.sv */
// pending_request_table_with_expiry_core_test: self-checking bench for the request table core
// drives actions through the stream input, predicts every result, compares field by field
// depends on prt_pkg and pending_request_table_with_expiry_core
module pending_request_table_with_expiry_core_test;

    localparam int DEPTH = 16;
    localparam int MAX_ERR_SHOWN = 10;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] seq;
        logic [31:0] handle;
        logic [31:0] prior;
        logic [31:0] now;
        logic        ignore;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] seq;
        logic [31:0] handle;
        logic [31:0] prior;
        logic [4:0]  removed;
        logic [4:0]  occ;
        logic        empty;
    } t_resp;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [135:0]  s_axis_tdata;   // action, seq, handle, prior, now, ignore
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [111:0]  m_axis_tdata;   // status, seq, handle, prior, removed, occ, empty
    logic          cfg_valid;
    logic          cfg_ready;
    logic [31:0]   cfg_data;

    pending_request_table_with_expiry_core #(.CAPACITY(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predictor state
    prt_pkg::t_entry table_q[$];
    logic [31:0]     age_limit;

    t_resp       pending_resp[$];
    int          mismatches;
    int          resp_seen;
    longint      cycles = 0;
    int          ops_seen[8];
    int          full_hits;

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("pending_request_table_with_expiry_core verification failed");
            $finish;
        end
    end

    function automatic logic aged_out(prt_pkg::t_entry e, logic [31:0] now);
        logic [31:0] age;
        age = now - e.stamp;
        return (age_limit == 0) || (age >= age_limit);
    endfunction

    function automatic t_resp table_apply(t_req r);
        t_resp           o;
        prt_pkg::t_entry kept[$];
        int              n;
        o = '0;
        case (r.action)
            prt_pkg::ACT_INSERT: begin
                if (table_q.size() >= DEPTH) o.status = prt_pkg::ST_FULL;
                else table_q.push_back('{r.seq, r.handle, r.prior, r.now});
            end
            prt_pkg::ACT_LOOKUP, prt_pkg::ACT_LOOKRM: begin
                o.status = prt_pkg::ST_MISS;
                foreach (table_q[i]) begin
                    if (table_q[i].seq == r.seq) begin
                        o.status = prt_pkg::ST_OK;
                        o.seq = table_q[i].seq;
                        o.handle = table_q[i].handle;
                        o.prior = table_q[i].prior;
                        if (r.action == prt_pkg::ACT_LOOKRM) begin
                            table_q.delete(i);
                            o.removed = 5'd1;
                        end
                        break;
                    end
                end
            end
            prt_pkg::ACT_RMHDL, prt_pkg::ACT_EXPIRE: begin
                n = 0;
                foreach (table_q[i]) begin
                    if (r.action == prt_pkg::ACT_RMHDL ? table_q[i].handle == r.handle
                                              : (r.ignore || aged_out(table_q[i], r.now)))
                        n++;
                    else kept.push_back(table_q[i]);
                end
                table_q = kept;
                o.removed = 5'(n);
                o.status = (n == 0) ? prt_pkg::ST_MISS : prt_pkg::ST_OK;
            end
            prt_pkg::ACT_POP: begin
                if (table_q.size() == 0 || !aged_out(table_q[0], r.now))
                    o.status = prt_pkg::ST_MISS;
                else begin
                    o.seq = table_q[0].seq;
                    o.handle = table_q[0].handle;
                    o.prior = table_q[0].prior;
                    o.removed = 5'd1;
                    void'(table_q.pop_front());
                end
            end
            default: ;
        endcase
        o.occ = 5'(table_q.size());
        o.empty = (table_q.size() == 0);
        return o;
    endfunction

    // receiver with random stalls
    int stall_left;
    always @(posedge i_clk) begin
        t_resp got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status  = m_axis_tdata[1:0];
                got.seq     = m_axis_tdata[33:2];
                got.handle  = m_axis_tdata[65:34];
                got.prior   = m_axis_tdata[97:66];
                got.removed = m_axis_tdata[102:98];
                got.occ     = m_axis_tdata[107:103];
                got.empty   = m_axis_tdata[108];
                resp_seen++;
                if (pending_resp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_ERR_SHOWN)
                        $display("unexpected result %h", got);
                end else begin
                    want = pending_resp.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_ERR_SHOWN)
                            $display("result %0d: st %0d/%0d seq %h/%h hdl %h/%h pri %h/%h rm %0d/%0d occ %0d/%0d emp %0d/%0d",
                                resp_seen, want.status, got.status, want.seq, got.seq,
                                want.handle, got.handle, want.prior, got.prior,
                                want.removed, got.removed, want.occ, got.occ,
                                want.empty, got.empty);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                           : $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_req(t_req r, bit fast);
        int gap;
        gap = fast ? 1 : (($urandom_range(0, 15) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(1, 3));
        repeat (gap) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, r.ignore, r.now, r.prior, r.handle, r.seq, r.action};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_resp.push_back(table_apply(r));
        ops_seen[r.action]++;
        if (r.action == prt_pkg::ACT_INSERT && pending_resp[$].status == prt_pkg::ST_FULL)
            full_hits++;
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
    endtask

    task automatic write_age(logic [31:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        age_limit = val;
        cfg_valid <= 1'b0;
    endtask

    function automatic t_req rand_req(int mode);
        t_req r;
        int   pick;
        r.action = 3'($urandom_range(0, 7));
        if (mode == 0 && $urandom_range(0, 2) != 0) r.action = prt_pkg::ACT_INSERT;
        r.seq = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 7);
        r.handle = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 3);
        r.prior = $urandom();
        r.now = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 200);
        r.ignore = ($urandom_range(0, 7) == 0);
        if (table_q.size() > 0 && $urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, table_q.size() - 1);
            r.seq = table_q[pick].seq;
            r.handle = table_q[pick].handle;
        end
        return r;
    endfunction

    typedef struct {
        t_req  req;
        bit    known;
        t_resp resp;
    } t_row;

    t_row directed[] = '{
        '{'{prt_pkg::ACT_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
          1, '{prt_pkg::ST_MISS, 0, 0, 0, 0, 0, 1}},
        '{'{prt_pkg::ACT_POP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
          1, '{prt_pkg::ST_MISS, 0, 0, 0, 0, 0, 1}},
        '{'{prt_pkg::ACT_RMHDL, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
          1, '{prt_pkg::ST_MISS, 0, 0, 0, 0, 0, 1}},
        '{'{prt_pkg::ACT_EXPIRE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1},
          1, '{prt_pkg::ST_MISS, 0, 0, 0, 0, 0, 1}},
        '{'{prt_pkg::ACT_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0},
          1, '{prt_pkg::ST_OK, 0, 0, 0, 0, 1, 0}},
        '{'{prt_pkg::ACT_INSERT, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1},
          1, '{prt_pkg::ST_OK, 0, 0, 0, 0, 2, 0}},
        '{'{prt_pkg::ACT_LOOKUP, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 1'b0},
          1, '{prt_pkg::ST_OK, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 2, 0}},
        '{'{3'd6, 32'h5, 32'h5, 32'h5, 32'h5, 1'b1},
          1, '{prt_pkg::ST_OK, 0, 0, 0, 0, 2, 0}},
        '{'{3'd7, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
          1, '{prt_pkg::ST_OK, 0, 0, 0, 0, 2, 0}},
        '{'{prt_pkg::ACT_LOOKRM, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
          1, '{prt_pkg::ST_OK, 0, 0, 0, 1, 1, 0}},
        '{'{prt_pkg::ACT_INSERT, 32'h1, 32'hA, 32'h11, 32'h10, 1'b0}, 0, '0},
        '{'{prt_pkg::ACT_INSERT, 32'h2, 32'hA, 32'h12, 32'h20, 1'b0}, 0, '0},
        '{'{prt_pkg::ACT_INSERT, 32'h1, 32'hB, 32'h13, 32'h30, 1'b0}, 0, '0},
        '{'{prt_pkg::ACT_LOOKRM, 32'h1, 32'h0, 32'h0, 32'h0, 1'b0}, 0, '0},
        '{'{prt_pkg::ACT_RMHDL, 32'h0, 32'hA, 32'h0, 32'h0, 1'b0}, 0, '0},
        '{'{prt_pkg::ACT_POP, 32'h0, 32'h0, 32'h0, 32'h40, 1'b0}, 0, '0},
        '{'{prt_pkg::ACT_EXPIRE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}, 0, '0}
    };

    initial begin
        t_req r;
        int   n_rand;
        mismatches = 0;
        resp_seen = 0;
        full_hits = 0;
        age_limit = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_req(directed[k].req, 1'b0);
            if (directed[k].known && pending_resp[$] !== directed[k].resp) begin
                mismatches++;
                if (mismatches <= MAX_ERR_SHOWN)
                    $display("directed row %0d predicts %h, table says %h",
                             k, pending_resp[$], directed[k].resp);
            end
        end

        // fill past capacity with wrapped time stamps, then aged pops and expiry
        write_age(32'd100);
        for (int k = 0; k < DEPTH + 2; k++) begin
            r = '{prt_pkg::ACT_INSERT, k, k % 3, $urandom(), 32'hFFFFFFC0 + k * 8, 1'b0};
            send_req(r, 1'b1);
        end
        send_req('{prt_pkg::ACT_POP, 0, 0, 0, 32'h10, 1'b0}, 1'b0);
        send_req('{prt_pkg::ACT_POP, 0, 0, 0, 32'hFFFFFFC1, 1'b0}, 1'b0);
        send_req('{prt_pkg::ACT_EXPIRE, 0, 0, 0, 32'h30, 1'b0}, 1'b0);
        write_age(32'hFFFFFFFF);
        send_req('{prt_pkg::ACT_EXPIRE, 0, 0, 0, 32'h0, 1'b1}, 1'b0);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_age(32'd0);
                1: write_age(32'd50);
                2: write_age(32'hFFFFFFFF);
                3: write_age($urandom_range(1, 300));
                4: write_age(32'd1);
                default: write_age($urandom());
            endcase
            n_rand = 300;
            for (int k = 0; k < n_rand; k++) begin
                send_req(rand_req((k / 40) % 2), (k % 100) < 15);
                if (k == 150) drain_results();
            end
        end

        drain_results();
        $display("covered %0d results: ins %0d look %0d lookrm %0d rmhdl %0d expire %0d pop %0d",
                 resp_seen, ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3],
                 ops_seen[4], ops_seen[5]);
        $display("unused codes %0d, inserts into a full table %0d, mismatches %0d",
                 ops_seen[6] + ops_seen[7], full_hits, mismatches);
        if (mismatches == 0 && pending_resp.size() == 0)
            $display("pending_request_table_with_expiry_core verification clean");
        else
            $display("pending_request_table_with_expiry_core verification failed");
        $finish;
    end

endmodule
